// ===== rtl/core/tll_pkg.sv =====
// ----------------------------------------------------------------------------
// tll_pkg
// Types, constants and character helpers shared by the tiny language lexer.
// ----------------------------------------------------------------------------
package tll_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int WIDE_WIDTH    = VALUE_WIDTH + 4;
	localparam int CHAR_WIDTH    = 8;
	localparam int KIND_WIDTH    = 3;
	localparam int MAX_TOKENS    = 3;
	localparam int TCNT_WIDTH    = $clog2(MAX_TOKENS + 1);
	localparam int TIDX_WIDTH    = $clog2(MAX_TOKENS);
	localparam int PROG_WIDTH    = 3;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PROG_WIDTH-1:0] KW_LEN = 3'd4;

	localparam logic [CHAR_WIDTH-1:0] CH_OPEN  = 8'h28;
	localparam logic [CHAR_WIDTH-1:0] CH_CLOSE = 8'h29;
	localparam logic [CHAR_WIDTH-1:0] CH_SEMI  = 8'h3B;
	localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;

	typedef enum logic [KIND_WIDTH-1:0] {
		TK_EXIT  = 3'd0,
		TK_INT   = 3'd1,
		TK_OPEN  = 3'd2,
		TK_CLOSE = 3'd3,
		TK_SEMI  = 3'd4,
		TK_ERROR = 3'd5,
		TK_END   = 3'd6
	} tok_kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_WORD   = 4'b0010,
		MODE_NUMBER = 4'b0100,
		MODE_ERROR  = 4'b1000
	} lex_mode_t;

	// tokens caused by one source byte
	typedef struct packed {
		logic [TCNT_WIDTH-1:0]              count;
		tok_kind_t [MAX_TOKENS-1:0]         kinds;
		logic [VALUE_WIDTH-1:0]             value;
		logic                               saturated;
	} tok_group_t;

	typedef struct packed {
		logic [PROG_WIDTH-1:0] prog;
		logic                  mismatch;
	} kw_state_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] acc;
		logic                   overflow;
	} num_state_t;

	function automatic logic is_alpha(input logic [CHAR_WIDTH-1:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [CHAR_WIDTH-1:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [CHAR_WIDTH-1:0] kw_char(input logic [1:0] pos);
		logic [CHAR_WIDTH-1:0] ch;
		case (pos)
			2'd0:    ch = 8'h65; // e
			2'd1:    ch = 8'h78; // x
			2'd2:    ch = 8'h69; // i
			default: ch = 8'h74; // t
		endcase
		return ch;
	endfunction

	function automatic kw_state_t word_step(input kw_state_t s,
			input logic [CHAR_WIDTH-1:0] c);
		kw_state_t r;
		r = s;
		if (!s.mismatch && s.prog < KW_LEN && c == kw_char(s.prog[1:0])) begin
			r.prog = s.prog + 1'b1;
		end else begin
			r.mismatch = 1'b1;
		end
		return r;
	endfunction

	// acc*10 + digit, clamped to the all-ones value
	function automatic num_state_t digit_step(input num_state_t s,
			input logic [CHAR_WIDTH-1:0] c);
		num_state_t             r;
		logic [WIDE_WIDTH-1:0]  ext;
		logic [WIDE_WIDTH-1:0]  wide;
		ext  = {{(WIDE_WIDTH-VALUE_WIDTH){1'b0}}, s.acc};
		wide = (ext << 3) + (ext << 1) + {{(WIDE_WIDTH-4){1'b0}}, c[3:0]};
		if (wide[WIDE_WIDTH-1:VALUE_WIDTH] != '0) begin
			r.acc      = '1;
			r.overflow = 1'b1;
		end else begin
			r.acc      = wide[VALUE_WIDTH-1:0];
			r.overflow = s.overflow;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/tll_char_if.sv =====
// ----------------------------------------------------------------------------
// tll_char_if
// Source byte channel: valid/ready handshake with byte and end flag.
// ----------------------------------------------------------------------------
interface tll_char_if;
	logic                           valid;
	logic                           ready;
	logic [tll_pkg::CHAR_WIDTH-1:0] char_byte;
	logic                           end_of_source;

	modport source (output valid, char_byte, end_of_source, input ready);
	modport sink (input valid, char_byte, end_of_source, output ready);
endinterface

// ===== rtl/core/tll_token_if.sv =====
// ----------------------------------------------------------------------------
// tll_token_if
// Token channel: valid/ready handshake with one token per transaction.
// ----------------------------------------------------------------------------
interface tll_token_if;
	logic                            valid;
	logic                            ready;
	logic [tll_pkg::KIND_WIDTH-1:0]  token_kind;
	logic [tll_pkg::VALUE_WIDTH-1:0] literal_value;
	logic                            value_saturated;
	logic                            last_of_run;

	modport source (output valid, token_kind, literal_value, value_saturated, last_of_run,
		input ready);
	modport sink (input valid, token_kind, literal_value, value_saturated, last_of_run,
		output ready);
endinterface

// ===== rtl/core/tll_lex_core.sv =====
// ----------------------------------------------------------------------------
// tll_lex_core
// Lexer state and the token group produced by one accepted source byte.
// ----------------------------------------------------------------------------
module tll_lex_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [tll_pkg::CHAR_WIDTH-1:0] char_byte,
	input  logic                           end_of_source,
	output tll_pkg::tok_group_t            group
);

	tll_pkg::lex_mode_t  mode_q, mode_d;
	tll_pkg::kw_state_t  kw_q, kw_d;
	tll_pkg::num_state_t num_q, num_d;

	always_comb begin
		logic idle_go;
		logic [tll_pkg::TCNT_WIDTH-1:0] n;
		idle_go = 1'b0;
		n       = '0;
		mode_d  = mode_q;
		kw_d    = kw_q;
		num_d   = num_q;
		group   = '0;

		case (mode_q)
			tll_pkg::MODE_WORD: begin
				if (tll_pkg::is_alpha(char_byte) || tll_pkg::is_digit(char_byte)) begin
					kw_d = tll_pkg::word_step(kw_q, char_byte);
				end else begin
					if (kw_q.prog == tll_pkg::KW_LEN && !kw_q.mismatch) begin
						group.kinds[n[tll_pkg::TIDX_WIDTH-1:0]] = tll_pkg::TK_EXIT;
						mode_d  = tll_pkg::MODE_IDLE;
						idle_go = 1'b1;
					end else begin
						// bad word: the byte that ended it is dropped
						group.kinds[n[tll_pkg::TIDX_WIDTH-1:0]] = tll_pkg::TK_ERROR;
						mode_d = tll_pkg::MODE_ERROR;
					end
					n    = n + 1'b1;
					kw_d = '0;
				end
			end
			tll_pkg::MODE_NUMBER: begin
				if (tll_pkg::is_digit(char_byte)) begin
					num_d = tll_pkg::digit_step(num_q, char_byte);
				end else begin
					group.kinds[n[tll_pkg::TIDX_WIDTH-1:0]] = tll_pkg::TK_INT;
					group.value     = num_q.acc;
					group.saturated = num_q.overflow;
					n       = n + 1'b1;
					num_d   = '0;
					mode_d  = tll_pkg::MODE_IDLE;
					idle_go = 1'b1;
				end
			end
			tll_pkg::MODE_IDLE: begin
				idle_go = 1'b1;
			end
			default: begin
			end
		endcase

		if (idle_go) begin
			if (tll_pkg::is_alpha(char_byte)) begin
				mode_d = tll_pkg::MODE_WORD;
				kw_d   = tll_pkg::word_step('0, char_byte);
			end else if (tll_pkg::is_digit(char_byte)) begin
				mode_d = tll_pkg::MODE_NUMBER;
				num_d  = tll_pkg::digit_step('0, char_byte);
			end else if (char_byte == tll_pkg::CH_OPEN) begin
				group.kinds[n[tll_pkg::TIDX_WIDTH-1:0]] = tll_pkg::TK_OPEN;
				n = n + 1'b1;
			end else if (char_byte == tll_pkg::CH_CLOSE) begin
				group.kinds[n[tll_pkg::TIDX_WIDTH-1:0]] = tll_pkg::TK_CLOSE;
				n = n + 1'b1;
			end else if (char_byte == tll_pkg::CH_SEMI) begin
				group.kinds[n[tll_pkg::TIDX_WIDTH-1:0]] = tll_pkg::TK_SEMI;
				n = n + 1'b1;
			end else if (!tll_pkg::is_space(char_byte)) begin
				group.kinds[n[tll_pkg::TIDX_WIDTH-1:0]] = tll_pkg::TK_ERROR;
				n      = n + 1'b1;
				mode_d = tll_pkg::MODE_ERROR;
			end
		end

		if (end_of_source) begin
			if (mode_d == tll_pkg::MODE_WORD) begin
				if (kw_d.prog == tll_pkg::KW_LEN && !kw_d.mismatch) begin
					group.kinds[n[tll_pkg::TIDX_WIDTH-1:0]] = tll_pkg::TK_EXIT;
				end else begin
					group.kinds[n[tll_pkg::TIDX_WIDTH-1:0]] = tll_pkg::TK_ERROR;
				end
				n = n + 1'b1;
			end else if (mode_d == tll_pkg::MODE_NUMBER) begin
				group.kinds[n[tll_pkg::TIDX_WIDTH-1:0]] = tll_pkg::TK_INT;
				group.value     = num_d.acc;
				group.saturated = num_d.overflow;
				n = n + 1'b1;
			end
			group.kinds[n[tll_pkg::TIDX_WIDTH-1:0]] = tll_pkg::TK_END;
			n      = n + 1'b1;
			mode_d = tll_pkg::MODE_IDLE;
			kw_d   = '0;
			num_d  = '0;
		end

		group.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tll_pkg::MODE_IDLE;
			kw_q   <= '0;
			num_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			kw_q   <= kw_d;
			num_q  <= num_d;
		end
	end

endmodule

// ===== rtl/core/tll_tok_queue.sv =====
// ----------------------------------------------------------------------------
// tll_tok_queue
// Small queue of token groups, unpacked one token per output transaction.
// ----------------------------------------------------------------------------
module tll_tok_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tll_pkg::tok_group_t group,
	output logic                full,
	tll_token_if.source         tokens
);

	tll_pkg::tok_group_t                 entry_q [tll_pkg::QUEUE_DEPTH];
	logic [tll_pkg::QPTR_WIDTH-1:0]      wr_ptr_q;
	logic [tll_pkg::QPTR_WIDTH-1:0]      rd_ptr_q;
	logic [tll_pkg::QCNT_WIDTH-1:0]      count_q;
	logic [tll_pkg::TIDX_WIDTH-1:0]      idx_q;

	tll_pkg::tok_group_t                 head;
	tll_pkg::tok_kind_t                  kind;
	logic                                last;
	logic                                pop;
	logic                                group_done;

	assign head       = entry_q[rd_ptr_q];
	assign kind       = head.kinds[idx_q];
	assign last       = (tll_pkg::TCNT_WIDTH'(idx_q) + 1'b1) == head.count;
	assign pop        = tokens.valid && tokens.ready;
	assign group_done = pop && last;
	assign full       = count_q == tll_pkg::QCNT_WIDTH'(tll_pkg::QUEUE_DEPTH);

	assign tokens.valid           = count_q != '0;
	assign tokens.token_kind      = kind;
	assign tokens.literal_value   = (kind == tll_pkg::TK_INT) ? head.value : '0;
	assign tokens.value_saturated = (kind == tll_pkg::TK_INT) && head.saturated;
	assign tokens.last_of_run     = last;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			idx_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (group_done) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				idx_q    <= '0;
			end else if (pop) begin
				idx_q <= idx_q + 1'b1;
			end
			case ({push, group_done})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/tiny_language_lexer.sv =====
// ----------------------------------------------------------------------------
// tiny_language_lexer
// Lexer for a tiny language: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// chars: one source byte per transaction, with end_of_source on the last
//   byte of a text. Up to one byte is taken every cycle while the queue is not full.
// tokens: one token per transaction (kind, literal value, saturation flag,
//   last_of_run on the final token caused by a byte). A byte causes zero to
//   three tokens; the last byte of a text always ends with an end token and
//   the lexer then starts over for the next text.
// Latency: the first token of a byte is offered in the cycle after the
//   byte is taken when no earlier tokens are waiting. Throughput is one byte
//   per cycle while the token rate keeps up; the output side drains one token
//   per cycle while tokens.ready is high.
// Tokens of each byte are held as one group in a four-entry queue; chars.ready
//   drops while that queue is full, so a stalled receiver backs up into the
//   source with nothing lost.
// Reset clears the lexer mode, keyword match, number accumulator and queue.
// ----------------------------------------------------------------------------
module tiny_language_lexer (
	input  logic      clk,
	input  logic      arst_n,
	tll_char_if.sink  chars,
	tll_token_if.source tokens
);

	tll_pkg::tok_group_t group;
	logic                accept;
	logic                full;

	assign chars.ready = !full;
	assign accept      = chars.valid && !full;

	tll_lex_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.char_byte     (chars.char_byte),
		.end_of_source (chars.end_of_source),
		.group         (group)
	);

	tll_tok_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && group.count != '0),
		.group  (group),
		.full   (full),
		.tokens (tokens)
	);

endmodule
